// ----- hw/rtl/ubds_pkg.sv -----
// ----------------------------------------------------------------------------
// ubds_pkg: shared types and constants
// Constants for the baud divisor search and the divider handshake structs.
// ----------------------------------------------------------------------------
package ubds_pkg;

   localparam logic [5:0]  RATIO_MIN       = 6'd4;
   localparam logic [5:0]  RATIO_MAX       = 6'd32;
   localparam logic [5:0]  BOTH_EDGE_LIMIT = 6'd8;
   localparam logic [31:0] CLOCK_RESET     = 32'd80000000;

   // request to the serial divider
   typedef struct packed {
      logic        start;
      logic [31:0] numer;
      logic [31:0] denom;
   } div_req_type;

   // response from the serial divider
   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

endpackage

// ----- hw/rtl/ubds_divider.sv -----
// ----------------------------------------------------------------------------
// ubds_divider: bit-serial restoring divider
// One quotient bit per cycle. A zero denominator
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module ubds_divider
   import ubds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quot_ff[31]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quot_in = div_req.numer;
         rem_in  = '0;
         den_in  = div_req.denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[30:0], ge};
         rem_in  = ge ? diff[31:0] : shifted[31:0];
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- hw/rtl/uart_baud_divisor_search_top.sv -----
// Sequence: for each of the 29 ratios, three serial divisions and a compare
//   step run; then the best setting is loaded into the result register.
// Requests: the next request is taken once the result register is loaded;
//   loading waits while an earlier result is stalled by rsp_ready.
// Reset: synchronous, active high; clears control state and sets
//   base_clock_hz to 80000000.
// ----------------------------------------------------------------------------
// uart_baud_divisor_search_top: oversampling ratio / divisor search
// Steps ratio 4..32, forms divisor and errors with a shared serial divider,
// and keeps the best setting.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search_top
   import ubds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_base_clock_hz,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_target_baud,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_oversample_ratio,
   output logic [15:0] rsp_baud_divisor,
   output logic        rsp_both_edge,
   output logic [31:0] rsp_baud_error
);

   typedef enum logic [3:0] {
      S_IDLE, S_D0, S_W0, S_D1, S_W1, S_D2, S_W2, S_PICK, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] clk_ff, clk_in;
   logic [23:0] baud_ff, baud_in;
   logic [5:0]  ratio_ff, ratio_in;
   logic [15:0] dv_ff, dv_in;
   logic [31:0] err_ff, err_in;
   logic [31:0] alt_ff, alt_in;
   logic [31:0] best_err_ff, best_err_in;
   logic [5:0]  best_ratio_ff, best_ratio_in;
   logic [15:0] best_div_ff, best_div_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  o_ratio_ff, o_ratio_in;
   logic [15:0] o_div_ff, o_div_in;
   logic        o_edge_ff, o_edge_in;
   logic [31:0] o_err_ff, o_err_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [24:0] mult_b;
   logic [30:0] prod;
   logic [31:0] cand_err;
   logic [15:0] cand_div;

   ubds_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared multiplier for the divider's denominator
   always_comb begin
      case (state_ff)
         S_D0:    mult_b = {1'b0, baud_ff};
         S_D1:    mult_b = {9'd0, dv_ff};
         default: mult_b = {8'd0, {1'b0, dv_ff} + 17'd1};
      endcase
      prod           = mult_b * ratio_ff;
      div_req.start  = (state_ff == S_D0) || (state_ff == S_D1) || (state_ff == S_D2);
      div_req.numer  = clk_ff;
      div_req.denom  = {1'b0, prod};
   end

   // nearer of divisor and divisor+1
   always_comb begin
      if (err_ff > alt_ff) begin
         cand_err = alt_ff;
         cand_div = dv_ff + 16'd1;
      end else begin
         cand_err = err_ff;
         cand_div = dv_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clk_in        = clk_ff;
      baud_in       = baud_ff;
      ratio_in      = ratio_ff;
      dv_in         = dv_ff;
      err_in        = err_ff;
      alt_in        = alt_ff;
      best_err_in   = best_err_ff;
      best_ratio_in = best_ratio_ff;
      best_div_in   = best_div_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      o_ratio_in    = o_ratio_ff;
      o_div_in      = o_div_ff;
      o_edge_in     = o_edge_ff;
      o_err_in      = o_err_ff;
      if (csr_valid) begin
         clk_in = csr_base_clock_hz;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               baud_in       = req_target_baud;
               ratio_in      = RATIO_MIN;
               best_err_in   = {8'd0, req_target_baud};
               best_ratio_in = '0;
               best_div_in   = '0;
               state_in      = S_D0;
            end
         end
         S_D0: state_in = S_W0;
         S_W0: begin
            if (div_rsp.done) begin
               dv_in    = (div_rsp.quot[15:0] == 16'd0) ? 16'd1 : div_rsp.quot[15:0];
               state_in = S_D1;
            end
         end
         S_D1: state_in = S_W1;
         S_W1: begin
            if (div_rsp.done) begin
               err_in   = div_rsp.quot - {8'd0, baud_ff};
               state_in = S_D2;
            end
         end
         S_D2: state_in = S_W2;
         S_W2: begin
            if (div_rsp.done) begin
               alt_in   = {8'd0, baud_ff} - div_rsp.quot;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (cand_err <= best_err_ff) begin
               best_err_in   = cand_err;
               best_ratio_in = ratio_ff;
               best_div_in   = cand_div;
            end
            if (ratio_ff == RATIO_MAX) begin
               state_in = S_DONE;
            end else begin
               ratio_in = ratio_ff + 6'd1;
               state_in = S_D0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_ratio_in   = best_ratio_ff;
               o_div_in     = best_div_ff;
               o_edge_in    = (best_ratio_ff >= RATIO_MIN) && (best_ratio_ff < BOTH_EDGE_LIMIT);
               o_err_in     = best_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      baud_ff       <= baud_in;
      ratio_ff      <= ratio_in;
      dv_ff         <= dv_in;
      err_ff        <= err_in;
      alt_ff        <= alt_in;
      best_err_ff   <= best_err_in;
      best_ratio_ff <= best_ratio_in;
      best_div_ff   <= best_div_in;
      o_ratio_ff    <= o_ratio_in;
      o_div_ff      <= o_div_in;
      o_edge_ff     <= o_edge_in;
      o_err_ff      <= o_err_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         clk_ff       <= CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_ff       <= clk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready            = 1'b1;
   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_oversample_ratio = o_ratio_ff;
   assign rsp_baud_divisor     = o_div_ff;
   assign rsp_both_edge        = o_edge_ff;
   assign rsp_baud_error       = o_err_ff;

endmodule

// ----- hw/rtl/ubds_checker.sv -----
// ----------------------------------------------------------------------------
// ubds_checker: port-level assertions
// Watches the top level's request and result ports; attached by bind.
// ----------------------------------------------------------------------------
module ubds_checker
   import ubds_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_oversample_ratio,
   input logic [15:0] rsp_baud_divisor,
   input logic        rsp_both_edge,
   input logic [31:0] rsp_baud_error
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_baud_divisor)
         && $stable(rsp_baud_error) && $stable(rsp_oversample_ratio))
      else $error("result changed while stalled");

   // both-edge flag follows the ratio
   a_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_both_edge == ((rsp_oversample_ratio >= RATIO_MIN)
         && (rsp_oversample_ratio < BOTH_EDGE_LIMIT)))
      else $error("both_edge mismatch");

   // no ratio selected means zero divisor
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oversample_ratio == 6'd0 |-> rsp_baud_divisor == 16'd0)
      else $error("divisor without ratio");

   // search runs after an accepted request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after request transfer");

   // no result in the first cycle out of reset
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind uart_baud_divisor_search_top ubds_checker u_ubds_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_oversample_ratio (rsp_oversample_ratio),
   .rsp_baud_divisor     (rsp_baud_divisor),
   .rsp_both_edge        (rsp_both_edge),
   .rsp_baud_error       (rsp_baud_error)
);
